/* rtl/step_detector_peak_valley_top_macros.svh */
// Assertion macros shared by the step detector RTL.
// Each macro expects clk and rst in scope.
`ifndef STEP_DETECTOR_PEAK_VALLEY_TOP_MACROS_SVH
`define STEP_DETECTOR_PEAK_VALLEY_TOP_MACROS_SVH

// Same-cycle implication.
`define SDPV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define SDPV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/sdpv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sdpv_pkg;

  localparam int unsigned MAG_W    = 15;
  localparam int unsigned SETTLE_W = 6;
  localparam int unsigned SINCE_W  = 8;
  localparam int unsigned REGST_W  = 4;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned CIDX_W   = 3;
  localparam int unsigned CDATA_W  = 15;

  localparam logic [CIDX_W-1:0] REG_MIN_SENS   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_HYSTERESIS = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SETTLE     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_TIMEOUT    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_REG_STEPS  = 3'd4;

  localparam logic [MAG_W-1:0]    RST_MIN_SENS   = 15'd2000;
  localparam logic [MAG_W-1:0]    RST_HYSTERESIS = 15'd500;
  localparam logic [SETTLE_W-1:0] RST_SETTLE     = 6'd5;
  localparam logic [SINCE_W-1:0]  RST_TIMEOUT    = 8'd50;
  localparam logic [REGST_W-1:0]  RST_REG_STEPS  = 4'd4;

  localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

  typedef struct packed {
    logic [MAG_W-1:0]    min_sens;
    logic [MAG_W-1:0]    hysteresis;
    logic [SETTLE_W-1:0] settle;
    logic [SINCE_W-1:0]  timeout;
    logic [REGST_W-1:0]  reg_steps;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/step_detector_peak_valley_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// A result passes through the input register and then the result register.
// Throughput: one sample per cycle while the output is not stalled; the detector state updates once per sample.
// A stalled output holds one result while the input register takes the next sample.
// Reset: synchronous, active high; restores register defaults and resets all detector state (seeking_peak set).
// Configuration writes take effect at the clock edge on which cfg_valid is high; cfg_ready is always high.

`include "step_detector_peak_valley_top_macros.svh"

module step_detector_peak_valley_top import sdpv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [MAG_W-1:0]   magnitude,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [TOTAL_W-1:0]      step_total,
  output logic                    step_event,
  output logic                    marker_level,
  output logic                    regulating,
  output logic [MAG_W-1:0]        midpoint_threshold,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic               in_full;
  logic [MAG_W-1:0]   in_mag;
  logic               fire;

  logic [MAG_W-1:0]   smoothed;
  logic [MAG_W-1:0]   peak_value;
  logic [MAG_W-1:0]   valley_value;
  logic [MAG_W-1:0]   threshold_avg;
  logic               seeking_peak;
  logic [SINCE_W-1:0] since_extreme;
  logic               regulation_on;
  logic [REGST_W-1:0] pending_steps;
  logic [TOTAL_W-1:0] count_total;
  logic               marker;

  logic [MAG_W-1:0]   smoothed_next;
  logic [MAG_W-1:0]   peak_value_next;
  logic [MAG_W-1:0]   valley_value_next;
  logic [MAG_W-1:0]   threshold_avg_next;
  logic               seeking_peak_next;
  logic [SINCE_W-1:0] since_extreme_next;
  logic               regulation_on_next;
  logic [REGST_W-1:0] pending_steps_next;
  logic [TOTAL_W-1:0] count_total_next;
  logic               marker_next;
  logic               event_next;

  assign cfg_ready = 1'b1;
  assign fire      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_sens   <= RST_MIN_SENS;
      cfg.hysteresis <= RST_HYSTERESIS;
      cfg.settle     <= RST_SETTLE;
      cfg.timeout    <= RST_TIMEOUT;
      cfg.reg_steps  <= RST_REG_STEPS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_SENS:   cfg.min_sens   <= cfg_data;
        REG_HYSTERESIS: cfg.hysteresis <= cfg_data;
        REG_SETTLE:     cfg.settle     <= cfg_data[SETTLE_W-1:0];
        REG_TIMEOUT:    cfg.timeout    <= cfg_data[SINCE_W-1:0];
        REG_REG_STEPS:  cfg.reg_steps  <= cfg_data[REGST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_mag <= magnitude;
    end
  end

  always_comb begin
    logic [MAG_W+1:0]   sm_sum;
    logic [MAG_W-1:0]   level;
    logic [MAG_W:0]     pk_diff;
    logic [MAG_W:0]     vl_diff;
    logic [MAG_W:0]     swing;
    logic [MAG_W:0]     mid_sum;
    logic [MAG_W-1:0]   mid;
    logic [MAG_W+1:0]   th_sum;
    logic [REGST_W-1:0] pend_inc;
    logic [REGST_W-1:0] add_amt;

    smoothed_next      = smoothed;
    peak_value_next    = peak_value;
    valley_value_next  = valley_value;
    threshold_avg_next = threshold_avg;
    seeking_peak_next  = seeking_peak;
    regulation_on_next = regulation_on;
    pending_steps_next = pending_steps;
    marker_next        = marker;
    add_amt            = '0;

    sm_sum = {2'b00, smoothed} + {1'b0, smoothed, 1'b0} + {2'b00, in_mag};
    level  = (smoothed == '0) ? in_mag : sm_sum[MAG_W+1:2];
    smoothed_next = level;

    since_extreme_next = (since_extreme == SINCE_MAX) ? SINCE_MAX
                                                      : since_extreme + 1'b1;

    pk_diff  = {1'b0, peak_value} - {1'b0, level};
    vl_diff  = {1'b0, level} - {1'b0, valley_value};
    swing    = {1'b0, peak_value} - {1'b0, valley_value};
    mid_sum  = {1'b0, peak_value} + {1'b0, valley_value};
    mid      = mid_sum[MAG_W:1];
    th_sum   = {2'b00, threshold_avg} + {1'b0, threshold_avg, 1'b0} + {2'b00, mid};
    pend_inc = pending_steps + 1'b1;

    if (seeking_peak) begin
      if (level > peak_value) begin
        peak_value_next    = level;
        since_extreme_next = '0;
      end else if (since_extreme_next > {2'b00, cfg.settle} && !pk_diff[MAG_W] &&
                   pk_diff[MAG_W-1:0] > cfg.hysteresis) begin
        seeking_peak_next  = 1'b0;
        valley_value_next  = level;
        since_extreme_next = '0;
      end
    end else begin
      if (level < valley_value) begin
        valley_value_next  = level;
        since_extreme_next = '0;
      end else if (since_extreme_next > {2'b00, cfg.settle} && !vl_diff[MAG_W] &&
                   vl_diff[MAG_W-1:0] > cfg.hysteresis) begin
        threshold_avg_next = (threshold_avg == '0) ? mid : th_sum[MAG_W+1:2];
        if (!swing[MAG_W] && swing[MAG_W-1:0] > cfg.min_sens) begin
          if (regulation_on) begin
            add_amt     = {{(REGST_W-1){1'b0}}, 1'b1};
            marker_next = !marker;
          end else if (pend_inc >= cfg.reg_steps) begin
            regulation_on_next = 1'b1;
            add_amt            = pend_inc;
            pending_steps_next = '0;
          end else begin
            pending_steps_next = pend_inc;
          end
        end else if (!regulation_on) begin
          pending_steps_next = '0;
        end
        seeking_peak_next  = 1'b1;
        peak_value_next    = level;
        since_extreme_next = '0;
      end
    end

    if (since_extreme_next > cfg.timeout) begin
      seeking_peak_next = 1'b1;
      peak_value_next   = level;
      if (!regulation_on_next) begin
        pending_steps_next = '0;
      end
    end

    count_total_next = count_total + {{(TOTAL_W-REGST_W){1'b0}}, add_amt};
    event_next       = (add_amt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed      <= '0;
      peak_value    <= '0;
      valley_value  <= '0;
      threshold_avg <= '0;
      seeking_peak  <= 1'b1;
      since_extreme <= '0;
      regulation_on <= 1'b0;
      pending_steps <= '0;
      count_total   <= '0;
      marker        <= 1'b0;
    end else if (fire) begin
      smoothed      <= smoothed_next;
      peak_value    <= peak_value_next;
      valley_value  <= valley_value_next;
      threshold_avg <= threshold_avg_next;
      seeking_peak  <= seeking_peak_next;
      since_extreme <= since_extreme_next;
      regulation_on <= regulation_on_next;
      pending_steps <= pending_steps_next;
      count_total   <= count_total_next;
      marker        <= marker_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      step_total         <= count_total_next;
      step_event         <= event_next;
      marker_level       <= marker_next;
      regulating         <= regulation_on_next;
      midpoint_threshold <= threshold_avg_next;
    end
  end

  `SDPV_ASSERT_NOW(a_event_needs_regulation, out_valid && step_event, regulating)
  `SDPV_ASSERT_NOW(a_pending_clear_in_regulation, regulation_on, pending_steps == '0)
  `SDPV_ASSERT_NEXT(a_marker_steady_before_regulation, fire && !regulation_on,
                    marker == $past(marker))
  `SDPV_ASSERT_NOW(a_stall_means_full, !in_ready, in_full && out_valid && !out_ready)

endmodule

`default_nettype wire
